>>> rtl/rdq_pkg.sv
// shared types, field widths and operation codes for the ring deque
`timescale 1ns / 1ps
package rdq_pkg;

    // fixed field widths of the command and result beats
    localparam int OP_W    = 3;
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int STAT_W  = 2;

    // default geometry
    localparam int DEF_DEPTH      = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH_TAIL = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_HEAD  = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_HEAD = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_TAIL = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

    // command beat
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [WORD_W-1:0]  data_in;
        logic [INDEX_W-1:0] index;
    } t_rdq_in;

    // result beat
    typedef struct packed {
        logic [WORD_W-1:0]  data_out;
        logic [COUNT_W-1:0] entry_count;
        logic [STAT_W-1:0]  status;
    } t_rdq_out;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_RDATA,
        S_SHIFT
    } t_state;

endpackage

>>> rtl/rdq_ram.sv
// entry store: one write port, one read port with registered read data
`timescale 1ns / 1ps
module rdq_ram #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [DATA_WIDTH-1:0] i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/ring_deque_with_indexed_access.sv
// ring deque top level: command decode, pointer state, shift sequencer
// push, pop, invalid and refused commands: result strobe the cycle after start, busy stays low,
//   so one command per cycle
// reads: one memory read, registered in the store, then in the result beat; busy in S_RDATA
// remove at index: S_SHIFT moves later entries; the single write port moves one entry a cycle
// synchronous active-low reset clears head, count and sequencer; stored words stay undefined
`timescale 1ns / 1ps
module ring_deque_with_indexed_access #(
    parameter int DEPTH      = rdq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = rdq_pkg::DEF_DATA_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  rdq_pkg::t_rdq_in i_cmd,
    output logic             busy,
    output logic             o_valid,
    output rdq_pkg::t_rdq_out o_result
);
    import rdq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > INDEX_W) ? CW : INDEX_W) + 1;

    // state
    t_state          r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_wr_slot;
    logic [AW-1:0]   r_rd_slot;
    logic [CW-1:0]   r_left;
    logic            r_valid;
    t_rdq_out        r_result;

    // decode
    logic            acc;
    logic            is_empty;
    logic            is_full;
    logic            bad_idx;
    logic [XW-1:0]   idx_x;
    logic [XW-1:0]   cnt_x;
    logic [XW-1:0]   off_x;
    logic [XW-1:0]   sum_x;
    logic [AW-1:0]   slot_a;
    logic [AW-1:0]   head_prev;
    logic [STAT_W-1:0] status_c;
    logic            op_ok;
    logic            is_read;
    logic            need_shift;

    // memory controls
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = a + AW'(1);
        end
        return r;
    endfunction

    assign busy = (r_state != S_IDLE);
    assign acc  = start && !busy;

    // command decode and slot address
    always_comb begin
        idx_x     = XW'(i_cmd.index);
        cnt_x     = XW'(r_count);
        is_empty  = (r_count == '0);
        is_full   = (r_count == CW'(DEPTH));
        bad_idx   = (idx_x >= cnt_x);
        head_prev = (r_head == '0) ? AW'(DEPTH - 1) : (r_head - AW'(1));
        status_c  = ST_OK;
        is_read   = 1'b0;
        off_x     = idx_x;
        unique case (i_cmd.op) inside
            OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                status_c = is_full ? ST_FULL : ST_OK;
                off_x    = cnt_x;
            end
            OP_POP_HEAD: begin
                status_c = is_empty ? ST_EMPTY : ST_OK;
            end
            OP_REMOVE, OP_READ_HEAD, OP_READ_TAIL: begin
                status_c = is_empty ? ST_EMPTY : (bad_idx ? ST_BADIDX : ST_OK);
                is_read  = (i_cmd.op != OP_REMOVE);
                if (i_cmd.op == OP_READ_TAIL) begin
                    off_x = cnt_x - XW'(1) - idx_x;
                end
            end
            default: begin
                status_c = ST_OK;
            end
        endcase
        sum_x      = XW'(r_head) + off_x;
        if (sum_x >= XW'(DEPTH)) begin
            sum_x = sum_x - XW'(DEPTH);
        end
        slot_a     = sum_x[AW-1:0];
        op_ok      = (status_c == ST_OK);
        need_shift = (i_cmd.op == OP_REMOVE) && op_ok && ((idx_x + XW'(1)) < cnt_x);
    end

    // head and count after an accepted command or at the end of a shift
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (acc && op_ok) begin
            case (i_cmd.op)
                OP_PUSH_TAIL: begin
                    n_count = r_count + CW'(1);
                end
                OP_PUSH_HEAD: begin
                    n_head  = head_prev;
                    n_count = r_count + CW'(1);
                end
                OP_POP_HEAD: begin
                    n_head  = next_slot(r_head);
                    n_count = r_count - CW'(1);
                end
                OP_REMOVE: begin
                    if (!need_shift) begin
                        n_count = r_count - CW'(1);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end else if (r_state == S_SHIFT && r_left == CW'(1)) begin
            n_count = r_count - CW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc && op_ok && is_read) begin
                    n_state = S_RDATA;
                end else if (acc && need_shift) begin
                    n_state = S_SHIFT;
                end
            end
            S_RDATA: begin
                n_state = S_IDLE;
            end
            S_SHIFT: begin
                if (r_left == CW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_a;
        ram_wdata = DATA_WIDTH'(i_cmd.data_in);
        ram_re    = 1'b0;
        ram_raddr = slot_a;
        unique case (r_state)
            S_IDLE: begin
                ram_we    = acc && op_ok &&
                            (i_cmd.op == OP_PUSH_TAIL || i_cmd.op == OP_PUSH_HEAD);
                ram_waddr = (i_cmd.op == OP_PUSH_HEAD) ? head_prev : slot_a;
                ram_re    = acc && ((op_ok && is_read) || need_shift);
                ram_raddr = is_read ? slot_a : next_slot(slot_a);
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_wr_slot;
                ram_wdata = ram_rdata;
                ram_re    = (r_left != CW'(1));
                ram_raddr = next_slot(r_rd_slot);
            end
            default: begin
                ram_we = 1'b0;
                ram_re = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_valid <= (acc && !((op_ok && is_read) || need_shift)) ||
                       (r_state == S_RDATA) ||
                       (r_state == S_SHIFT && r_left == CW'(1));
        end
    end

    // result beat and shift pointers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_result.data_out    <= '0;
            r_result.entry_count <= COUNT_W'(n_count);
            r_result.status      <= status_c;
            r_wr_slot            <= slot_a;
            r_rd_slot            <= next_slot(slot_a);
            r_left               <= CW'(cnt_x - XW'(1) - idx_x);
        end else if (r_state == S_RDATA) begin
            r_result.data_out    <= WORD_W'(ram_rdata);
            r_result.entry_count <= COUNT_W'(r_count);
            r_result.status      <= ST_OK;
        end else if (r_state == S_SHIFT) begin
            r_wr_slot            <= r_rd_slot;
            r_rd_slot            <= next_slot(r_rd_slot);
            r_left               <= r_left - CW'(1);
            r_result.data_out    <= '0;
            r_result.entry_count <= COUNT_W'(n_count);
            r_result.status      <= ST_OK;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    rdq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

`ifndef SYNTH
    // fill count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above capacity");

    // shift never reads the slot it writes in the same cycle
    a_shift_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && ram_re) |-> (ram_raddr != ram_waddr))
        else $error("shift read and write hit the same slot");

    // a good read answers once its memory read data has been registered
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && op_ok && is_read) |=> !o_valid ##1 o_valid)
        else $error("read result not on time");

    // full status only when the store is at capacity
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_FULL) |-> (r_count == CW'(DEPTH)))
        else $error("full status while not full");
`endif

endmodule

>>> bench/ring_deque_with_indexed_access_tb.sv
// self-checking testbench for the ring deque with indexed access
`timescale 1ns / 1ps
module ring_deque_with_indexed_access_tb;
    import rdq_pkg::*;

    localparam int DEPTH      = DEF_DEPTH;
    localparam int RAND_ITEMS = 1150;
    localparam int END_WAIT   = 2 * DEPTH + 16;
    localparam int CYCLE_CAP  = 600000;

    // op codes the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        t_rdq_in cmd;
        bit      drain;
    } t_cmd_entry;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_rdq_in   i_cmd;
    logic      busy;
    logic      o_valid;
    t_rdq_out  o_result;

    // commands waiting to be driven and results waiting to arrive
    t_cmd_entry cmd_backlog[$];
    t_rdq_out   awaited_results[$];
    t_cmd_entry next_entry;

    // predicted deque contents
    logic [WORD_W-1:0]  mdl_store [DEPTH];
    logic [INDEX_W-1:0] mdl_head;
    logic [COUNT_W-1:0] mdl_fill;

    // fill level seen by the stimulus generator, used to aim indexes
    int unsigned shadow_fill;

    int  err_count;
    int  cycle_count;
    bit  cmd_taken;
    int  gap_left;
    int  no_idle_left;
    t_rdq_out want;

    ring_deque_with_indexed_access u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // predict the result of one command and update the predicted deque
    function automatic t_rdq_out deque_apply(t_rdq_in c);
        t_rdq_out    r;
        int unsigned idx;
        int unsigned i;
        r = '0;
        r.status = ST_OK;
        idx = 32'(c.index);
        case (c.op)
            OP_PUSH_TAIL, OP_PUSH_HEAD: begin
                if (mdl_fill >= DEPTH) begin
                    r.status = ST_FULL;
                end else if (c.op == OP_PUSH_TAIL) begin
                    mdl_store[INDEX_W'(mdl_head + mdl_fill)] = c.data_in;
                    mdl_fill++;
                end else begin
                    mdl_head = mdl_head - 1'b1;
                    mdl_store[mdl_head] = c.data_in;
                    mdl_fill++;
                end
            end
            OP_POP_HEAD: begin
                if (mdl_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    mdl_head = mdl_head + 1'b1;
                    mdl_fill--;
                end
            end
            OP_REMOVE, OP_READ_HEAD, OP_READ_TAIL: begin
                if (mdl_fill == 0) begin
                    r.status = ST_EMPTY;
                end else if (idx >= mdl_fill) begin
                    r.status = ST_BADIDX;
                end else if (c.op == OP_REMOVE) begin
                    // later entries slide one place toward the head
                    for (i = idx; i + 1 < mdl_fill; i++) begin
                        mdl_store[INDEX_W'(mdl_head + i)] = mdl_store[INDEX_W'(mdl_head + i + 1)];
                    end
                    mdl_fill--;
                end else if (c.op == OP_READ_HEAD) begin
                    r.data_out = mdl_store[INDEX_W'(mdl_head + idx)];
                end else begin
                    r.data_out = mdl_store[INDEX_W'(mdl_head + mdl_fill - 1 - idx)];
                end
            end
            default: ;
        endcase
        r.entry_count = mdl_fill;
        return r;
    endfunction

    // queue one command and track the fill level it leaves behind
    task automatic queue_cmd(logic [OP_W-1:0] op, logic [WORD_W-1:0] word,
                             logic [INDEX_W-1:0] idx, bit drain = 1'b0);
        t_cmd_entry e;
        e.cmd.op      = op;
        e.cmd.data_in = word;
        e.cmd.index   = idx;
        e.drain       = drain;
        cmd_backlog.push_back(e);
        case (op)
            OP_PUSH_TAIL, OP_PUSH_HEAD: if (shadow_fill < DEPTH) shadow_fill++;
            OP_POP_HEAD:                if (shadow_fill > 0) shadow_fill--;
            OP_REMOVE:                  if (shadow_fill > 0 && idx < shadow_fill) shadow_fill--;
            default: ;
        endcase
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // index that lands inside the current entries, or any index when empty
    function automatic logic [INDEX_W-1:0] live_index();
        if (shadow_fill == 0) return INDEX_W'($urandom());
        return INDEX_W'($urandom_range(0, shadow_fill - 1));
    endfunction

    // result check and command capture
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("Simulation FAILED");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with nothing outstanding: %h", o_result);
                    err_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_result.data_out !== want.data_out) begin
                        $error("data_out exp %h act %h", want.data_out, o_result.data_out);
                        err_count++;
                    end
                    if (o_result.entry_count !== want.entry_count) begin
                        $error("entry_count exp %0d act %0d", want.entry_count,
                               o_result.entry_count);
                        err_count++;
                    end
                    if (o_result.status !== want.status) begin
                        $error("status exp %0d act %0d", want.status, o_result.status);
                        err_count++;
                    end
                end
            end
            if (start && !busy) begin
                awaited_results.push_back(deque_apply(i_cmd));
                cmd_taken = 1'b1;
            end
        end
    end

    // command driver, changes inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !cmd_taken) begin
            // hold the beat until it is taken
        end else begin
            if (cmd_taken) begin
                cmd_taken = 1'b0;
                if (no_idle_left > 0) begin
                    no_idle_left--;
                    gap_left = 0;
                end else begin
                    gap_left = $urandom_range(0, 6);
                    if ($urandom_range(0, 39) == 0) no_idle_left = $urandom_range(20, 60);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].drain && awaited_results.size() > 0)) begin
                next_entry = cmd_backlog.pop_front();
                start <= 1'b1;
                i_cmd <= next_entry.cmd;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial begin
        int          made;
        int          n;
        int          k;
        logic [OP_W-1:0] op;

        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = '0;
        err_count    = 0;
        cycle_count  = 0;
        cmd_taken    = 1'b0;
        gap_left     = 0;
        no_idle_left = 0;
        mdl_head     = '0;
        mdl_fill     = '0;
        shadow_fill  = 0;
        foreach (mdl_store[j]) mdl_store[j] = '0;

        // directed: empty cases, spare ops, edge words, edge indexes
        queue_cmd(OP_POP_HEAD, '0, '0);
        queue_cmd(OP_READ_HEAD, '0, '0);
        queue_cmd(OP_READ_TAIL, '0, '1);
        queue_cmd(OP_REMOVE, '0, '0);
        queue_cmd(OP_SPARE_6, '1, '1);
        queue_cmd(OP_SPARE_7, '1, '0);
        queue_cmd(OP_PUSH_TAIL, 32'hFFFF_FFFF, '1);
        queue_cmd(OP_PUSH_HEAD, 32'h0000_0000, '0);
        queue_cmd(OP_PUSH_TAIL, 32'hA5A5_A5A5, '0);
        queue_cmd(OP_PUSH_HEAD, 32'h5A5A_5A5A, '0);
        queue_cmd(OP_READ_HEAD, '0, 6'd0);
        queue_cmd(OP_READ_HEAD, '0, 6'd3);
        queue_cmd(OP_READ_TAIL, '0, 6'd0);
        queue_cmd(OP_READ_TAIL, '0, 6'd3);
        queue_cmd(OP_READ_HEAD, '0, 6'd4);
        queue_cmd(OP_READ_TAIL, '0, 6'd63);
        queue_cmd(OP_REMOVE, '0, 6'd63);
        queue_cmd(OP_REMOVE, '0, 6'd1);
        queue_cmd(OP_READ_HEAD, '0, 6'd1);
        queue_cmd(OP_REMOVE, '0, 6'd0);
        queue_cmd(OP_READ_TAIL, '0, 6'd0);
        queue_cmd(OP_POP_HEAD, '0, '0);
        queue_cmd(OP_POP_HEAD, '0, '0);
        queue_cmd(OP_POP_HEAD, '0, '0);

        // random: mostly shaped runs, some noise
        made = 0;
        while (made < RAND_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom_range(1, 40);
                    for (k = 0; k < n; k++) begin
                        op = $urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD;
                        queue_cmd(op, rand_word(), INDEX_W'($urandom()));
                    end
                    made += n;
                end
                3: begin
                    n = $urandom_range(1, 20);
                    for (k = 0; k < n; k++) queue_cmd(OP_POP_HEAD, $urandom(), INDEX_W'($urandom()));
                    made += n;
                end
                4, 5, 6: begin
                    n = $urandom_range(1, 20);
                    for (k = 0; k < n; k++) begin
                        op = $urandom_range(0, 1) ? OP_READ_HEAD : OP_READ_TAIL;
                        queue_cmd(op, $urandom(), live_index());
                    end
                    made += n;
                end
                7: begin
                    n = $urandom_range(1, 8);
                    for (k = 0; k < n; k++) queue_cmd(OP_REMOVE, $urandom(), live_index());
                    made += n;
                end
                8: begin
                    n = $urandom_range(1, 12);
                    for (k = 0; k < n; k++) begin
                        op = OP_W'($urandom_range(0, 7));
                        queue_cmd(op, rand_word(), INDEX_W'($urandom()));
                        if (op <= OP_READ_TAIL) made++;
                    end
                end
                default: begin
                    // wait for the pipe to empty, then run the deque full and probe its ends
                    queue_cmd(OP_READ_HEAD, '0, live_index(), 1'b1);
                    made++;
                    while (shadow_fill < DEPTH) begin
                        queue_cmd($urandom_range(0, 1) ? OP_PUSH_TAIL : OP_PUSH_HEAD,
                                  rand_word(), INDEX_W'($urandom()));
                        made++;
                    end
                    queue_cmd(OP_PUSH_TAIL, rand_word(), '0);
                    queue_cmd(OP_PUSH_HEAD, rand_word(), '1);
                    queue_cmd(OP_READ_HEAD, '0, 6'd63);
                    queue_cmd(OP_READ_TAIL, '0, 6'd63);
                    queue_cmd(OP_REMOVE, '0, INDEX_W'($urandom_range(0, 63)));
                    made += 5;
                end
            endcase
        end

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (cmd_backlog.size() == 0 && !start && awaited_results.size() == 0);
        repeat (END_WAIT) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/rdq_pkg.sv
rtl/rdq_ram.sv
rtl/ring_deque_with_indexed_access.sv
bench/ring_deque_with_indexed_access_tb.sv
